>>> hdl/pkcl_pkg.sv
// ---------------------------------------------------------------------------
// pkcl_pkg
// Shared types and constants for the PKCS#7 certificate locator.
// ---------------------------------------------------------------------------
`default_nettype none

package pkcl_pkg;

    // Longest buffer accepted, in bytes
    localparam int MAX_BYTES = 8192;

    // Field widths
    localparam int BYTE_W = 8;
    localparam int STAT_W = 3;
    localparam int OFF_W  = 13;
    localparam int CLEN_W = 14;
    localparam int LEN_W  = 32;
    localparam int POS_W  = $clog2(MAX_BYTES + 1);
    localparam int TOT_W  = CLEN_W + 1;
    localparam int END_W  = TOT_W + 1;
    localparam int LCNT_W = 3;

    // Header constants
    localparam logic [BYTE_W-1:0] TAG_SEQ  = 8'h30;
    localparam logic [BYTE_W-1:0] TAG_OID  = 8'h06;
    localparam logic [BYTE_W-1:0] TAG_CTX0 = 8'hA0;
    localparam logic [LCNT_W-1:0] MAX_LEN_BYTES = 3'd4;
    localparam logic [1:0]        LAST_ITEM     = 2'd2;
    localparam logic [POS_W-1:0]  MAX_POS       = POS_W'(MAX_BYTES);

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_WRONG_TAG = 3'd1,
        ST_BAD_LEN   = 3'd2,
        ST_RAN_OUT   = 3'd3,
        ST_PAST_END  = 3'd4,
        ST_TOO_LONG  = 3'd5
    } t_status;

    // Position on the fixed header path
    typedef enum logic [7:0] {
        PH_OUTER  = 8'b0000_0001,
        PH_OID    = 8'b0000_0010,
        PH_CTX0   = 8'b0000_0100,
        PH_SIGNED = 8'b0000_1000,
        PH_ITEMS  = 8'b0001_0000,
        PH_CERTS  = 8'b0010_0000,
        PH_CERT   = 8'b0100_0000,
        PH_DONE   = 8'b1000_0000
    } t_phase;

    // Step within one tag-length header
    typedef enum logic [2:0] {
        HS_TAG  = 3'b001,
        HS_LEN1 = 3'b010,
        HS_LENN = 3'b100
    } t_hstep;

    // State captured at the last byte of a buffer
    typedef struct packed {
        t_status          err;
        logic             done;
        logic [POS_W-1:0] start;
        logic [TOT_W-1:0] total;
        logic             big;
        logic [POS_W-1:0] pos;
    } t_fin;

endpackage

`default_nettype wire

>>> hdl/pkcl_in_if.sv
// ---------------------------------------------------------------------------
// pkcl_in_if
// Byte stream channel: one buffer byte and its last-byte mark per transfer.
// ---------------------------------------------------------------------------
`default_nettype none

interface pkcl_in_if;
    import pkcl_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

>>> hdl/pkcl_out_if.sv
// ---------------------------------------------------------------------------
// pkcl_out_if
// Result channel: status, certificate offset and length per transfer.
// ---------------------------------------------------------------------------
`default_nettype none

interface pkcl_out_if;
    import pkcl_pkg::*;

    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [OFF_W-1:0]  cert_offset;
    logic [CLEN_W-1:0] cert_length;

    modport source (output valid, output status, output cert_offset,
                    output cert_length, input ready);
    modport sink   (input valid, input status, input cert_offset,
                    input cert_length, output ready);
endinterface

`default_nettype wire

>>> hdl/pkcs7_certificate_locator_core.sv
// ---------------------------------------------------------------------------
// pkcs7_certificate_locator_core
// Streaming DER header walker that finds the first certificate of a
// PKCS#7 SignedData buffer and reports its offset and total length.
// ---------------------------------------------------------------------------
//
//  Channel  Dir  Moves per transfer
//  i_in     in   data_byte, last_byte (one buffer byte)
//  o_out    out  status, cert_offset, cert_length (one per buffer)
//
//  One byte per cycle while not stalled. Three register stages: input register,
//  header walk with end-of-buffer snapshot, result register; a buffer's last
//  byte goes through the input register and snapshot before its result is registered.
//  Reset (i_rst_n low, synchronous) returns the walker to the outer tag.
//  A stalled result holds the result register; the walk and i_in.ready
//  stall only while a finished snapshot also waits behind it.
// ---------------------------------------------------------------------------
`default_nettype none

module pkcs7_certificate_locator_core (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pkcl_in_if.sink   i_in,
    pkcl_out_if.source o_out
);
    import pkcl_pkg::*;

    // Result register advance: empty or being taken
    logic out_adv;
    // Walk advance: snapshot empty or moving into the result register
    logic adv;

    // Input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;

    // Walker state
    t_phase            r_phase,  n_phase;
    t_hstep            r_hstep,  n_hstep;
    logic [LEN_W-1:0]  r_acc,    n_acc;
    logic [LCNT_W-1:0] r_left,   n_left;
    logic [LEN_W-1:0]  r_skip,   n_skip;
    logic [1:0]        r_items,  n_items;
    logic [POS_W-1:0]  r_pos,    n_pos;
    logic [POS_W-1:0]  r_start,  n_start;
    logic [TOT_W-1:0]  r_total,  n_total;
    logic              r_big,    n_big;
    t_status           r_err,    n_err;

    // End-of-buffer snapshot
    logic r_fin_valid;
    t_fin r_fin, n_fin;

    // Result register
    logic              r_out_valid;
    t_status           r_status, n_status;
    logic [OFF_W-1:0]  r_off,    n_off;
    logic [CLEN_W-1:0] r_len,    n_len;

    // Per-byte helpers
    logic [BYTE_W-1:0] want;
    logic [LEN_W-1:0]  acc_new;
    logic              len_done;
    logic [BYTE_W-2:0] nbytes;
    logic [POS_W-1:0]  hdr_len;
    logic [END_W-1:0]  cert_end;

    assign out_adv    = !r_out_valid || o_out.ready;
    assign adv        = !r_fin_valid || out_adv;
    assign i_in.ready = adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (adv) begin
            r_in_valid <= i_in.valid;
        end
        if (adv) begin
            r_in_byte <= i_in.data_byte;
            r_in_last <= i_in.last_byte;
        end
    end

    // Expected tag for the current phase
    always_comb begin
        unique case (r_phase)
            PH_OUTER:  want = TAG_SEQ;
            PH_OID:    want = TAG_OID;
            PH_CTX0:   want = TAG_CTX0;
            PH_SIGNED: want = TAG_SEQ;
            PH_CERTS:  want = TAG_CTX0;
            default:   want = TAG_SEQ;
        endcase
    end

    assign nbytes  = r_in_byte[BYTE_W-2:0];
    assign hdr_len = r_pos + POS_W'(1) - r_start;

    // Header walk for one byte
    always_comb begin
        n_phase  = r_phase;
        n_hstep  = r_hstep;
        n_acc    = r_acc;
        n_left   = r_left;
        n_skip   = r_skip;
        n_items  = r_items;
        n_pos    = r_pos;
        n_start  = r_start;
        n_total  = r_total;
        n_big    = r_big;
        n_err    = r_err;
        acc_new  = r_acc;
        len_done = 1'b0;
        n_fin    = r_fin;

        if (r_in_valid) begin
            if (r_pos >= MAX_POS) begin
                if (r_err == ST_OK) begin
                    n_err = ST_TOO_LONG;
                end
            end else begin
                n_pos = r_pos + POS_W'(1);
                if (r_err == ST_OK && r_phase != PH_DONE) begin
                    if (r_skip != '0) begin
                        n_skip = r_skip - LEN_W'(1);
                    end else begin
                        unique case (r_hstep)
                            HS_TAG: begin
                                if (r_phase != PH_ITEMS && r_in_byte != want) begin
                                    n_err = ST_WRONG_TAG;
                                end else begin
                                    if (r_phase == PH_CERT) begin
                                        n_start = r_pos;
                                    end
                                    n_hstep = HS_LEN1;
                                end
                            end
                            HS_LEN1: begin
                                if (!r_in_byte[7]) begin
                                    acc_new  = LEN_W'(r_in_byte);
                                    len_done = 1'b1;
                                end else if (nbytes == '0 ||
                                             nbytes > (BYTE_W-1)'(MAX_LEN_BYTES)) begin
                                    n_err = ST_BAD_LEN;
                                end else begin
                                    n_acc   = '0;
                                    n_left  = nbytes[LCNT_W-1:0];
                                    n_hstep = HS_LENN;
                                end
                            end
                            HS_LENN: begin
                                acc_new  = {r_acc[LEN_W-BYTE_W-1:0], r_in_byte};
                                n_acc    = acc_new;
                                n_left   = r_left - LCNT_W'(1);
                                len_done = (r_left == LCNT_W'(1));
                            end
                            default: begin
                                n_hstep = HS_TAG;
                            end
                        endcase
                    end
                end
            end

            // Complete length: advance along the path
            if (len_done) begin
                n_hstep = HS_TAG;
                n_acc   = acc_new;
                unique case (r_phase)
                    PH_OUTER:  n_phase = PH_OID;
                    PH_OID: begin
                        n_skip  = acc_new;
                        n_phase = PH_CTX0;
                    end
                    PH_CTX0:   n_phase = PH_SIGNED;
                    PH_SIGNED: begin
                        n_phase = PH_ITEMS;
                        n_items = '0;
                    end
                    PH_ITEMS: begin
                        n_skip  = acc_new;
                        n_items = r_items + 2'd1;
                        if (r_items == LAST_ITEM) begin
                            n_phase = PH_CERTS;
                        end
                    end
                    PH_CERTS:  n_phase = PH_CERT;
                    PH_CERT: begin
                        n_total = TOT_W'(acc_new[CLEN_W-1:0]) + TOT_W'(hdr_len);
                        n_big   = |acc_new[LEN_W-1:CLEN_W];
                        n_phase = PH_DONE;
                    end
                    default: n_phase = r_phase;
                endcase
            end

            // Last byte: capture the outcome and restart
            if (r_in_last) begin
                n_fin.err   = n_err;
                n_fin.done  = (n_phase == PH_DONE);
                n_fin.start = n_start;
                n_fin.total = n_total;
                n_fin.big   = n_big;
                n_fin.pos   = n_pos;
                n_phase = PH_OUTER;
                n_hstep = HS_TAG;
                n_acc   = '0;
                n_left  = '0;
                n_skip  = '0;
                n_items = '0;
                n_pos   = '0;
                n_start = '0;
                n_total = '0;
                n_big   = 1'b0;
                n_err   = ST_OK;
            end
        end
    end

    // Walker state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_OUTER;
            r_hstep     <= HS_TAG;
            r_acc       <= '0;
            r_left      <= '0;
            r_skip      <= '0;
            r_items     <= '0;
            r_pos       <= '0;
            r_start     <= '0;
            r_total     <= '0;
            r_big       <= 1'b0;
            r_err       <= ST_OK;
            r_fin_valid <= 1'b0;
        end else if (adv) begin
            r_phase     <= n_phase;
            r_hstep     <= n_hstep;
            r_acc       <= n_acc;
            r_left      <= n_left;
            r_skip      <= n_skip;
            r_items     <= n_items;
            r_pos       <= n_pos;
            r_start     <= n_start;
            r_total     <= n_total;
            r_big       <= n_big;
            r_err       <= n_err;
            r_fin_valid <= r_in_valid && r_in_last;
        end
        if (adv) begin
            r_fin <= n_fin;
        end
    end

    // Final status from the snapshot
    assign cert_end = END_W'(r_fin.start) + END_W'(r_fin.total);

    always_comb begin
        n_status = ST_OK;
        n_off    = '0;
        n_len    = '0;
        if (r_fin.err != ST_OK) begin
            n_status = r_fin.err;
        end else if (!r_fin.done) begin
            n_status = ST_RAN_OUT;
        end else if (r_fin.big || cert_end > END_W'(r_fin.pos)) begin
            n_status = ST_PAST_END;
        end else begin
            n_off = r_fin.start[OFF_W-1:0];
            n_len = r_fin.total[CLEN_W-1:0];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_fin_valid;
        end
        if (out_adv) begin
            r_status <= n_status;
            r_off    <= n_off;
            r_len    <= n_len;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_status;
    assign o_out.cert_offset = r_off;
    assign o_out.cert_length = r_len;

endmodule

`default_nettype wire
